// ===== rtl/pcicfg_pkg.sv =====
`timescale 1ns / 1ps

package pcicfg_pkg;

    // Largest number of BAR slots in a type-0 header
    localparam int MAX_BARS = 6;

    // Access status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_DEV_SPECIFIC = 2'd1,
        ST_READ_ONLY    = 2'd2,
        ST_BAD_SIZE     = 2'd3
    } status_t;

    // Access size codes
    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_HALF  = 2'd1;
    localparam logic [1:0] SZ_DWORD = 2'd2;
    localparam logic [1:0] SZ_BAD   = 2'd3;

    // Access direction
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_ID        = 3'd0;
    localparam logic [2:0] CFG_CLASS     = 3'd1;
    localparam logic [2:0] CFG_HEADER    = 3'd2;
    localparam logic [2:0] CFG_IRQ       = 3'd3;
    localparam logic [2:0] CFG_SUBSYSTEM = 3'd4;
    localparam logic [2:0] CFG_CMD_STAT  = 3'd5;
    localparam logic [2:0] CFG_BAR_SIZE  = 3'd6;
    localparam logic [2:0] CFG_BAR_IO    = 3'd7;

    // Header byte offsets
    localparam logic [7:0] OFS_COMMAND   = 8'h04;
    localparam logic [7:0] OFS_STATUS    = 8'h06;
    localparam logic [7:0] OFS_REVISION  = 8'h08;
    localparam logic [7:0] OFS_CACHE     = 8'h0C;
    localparam logic [7:0] OFS_LATENCY   = 8'h0D;
    localparam logic [7:0] OFS_BIST      = 8'h0F;
    localparam logic [7:0] OFS_HDR_TYPE  = 8'h0E;
    localparam logic [7:0] OFS_CLASS     = 8'h0B;
    localparam logic [7:0] OFS_ROM       = 8'h30;
    localparam logic [7:0] OFS_INT_LINE  = 8'h3C;
    localparam logic [7:0] OFS_INT_PIN   = 8'h3D;
    localparam logic [7:0] OFS_MIN_GNT   = 8'h3E;
    localparam logic [7:0] OFS_MAX_LAT   = 8'h3F;
    localparam logic [7:0] OFS_DEV_SPEC  = 8'h40;

    // Header dword indexes
    localparam logic [3:0] W_ID        = 4'd0;
    localparam logic [3:0] W_CMD_STAT  = 4'd1;
    localparam logic [3:0] W_CLASS     = 4'd2;
    localparam logic [3:0] W_HEADER    = 4'd3;
    localparam logic [3:0] W_BAR0      = 4'd4;
    localparam logic [3:0] W_SUBSYSTEM = 4'd11;
    localparam logic [3:0] W_ROM       = 4'd12;
    localparam logic [3:0] W_IRQ       = 4'd15;

    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] ROM_PROBE = 32'hFFFF_FFFE;

    // One configuration access request
    typedef struct packed {
        logic        mode;
        logic [7:0]  offset;
        logic [1:0]  size_code;
        logic [31:0] write_data;
    } req_t;

    // Result of one access
    typedef struct packed {
        logic [31:0]         read_data;
        status_t             access_status;
        logic                range_changed;
        logic [MAX_BARS-1:0] active_bars;
    } rsp_t;

    // BAR size mask from its 6-bit size code; zero for no BAR or oversized codes
    function automatic logic [31:0] bar_size_mask(input logic [5:0] code);
        logic [31:0] mask;
        begin
            if (code == 6'd0 || code > 6'd32)
            begin
                mask = 32'd0;
            end
            else
            begin
                mask = ALL_ONES << (code - 6'd1);
            end
            return mask;
        end
    endfunction

endpackage

// ===== rtl/pci_config_header_registers_core.sv =====
`timescale 1ns / 1ps

// Type-0 PCI configuration header. Each request (read or write, byte offset,
// size of 1, 2 or 4 bytes) is registered on entry, decoded against the header
// state combinationally and its response registered on exit; one request per
// cycle is sustained while the output is not stalled. The header state is
// updated when a request moves into the response register, so every request
// sees all earlier writes. Configuration writes preset the read-only fields
// and the reset values of command, status, cache line, latency timer,
// interrupt line and the BAR type bits; issue them only while no request is
// in flight. Offsets at 0x40 and above return device-specific status.
module pci_config_header_registers_core
    import pcicfg_pkg::*;
#(
    parameter int NUM_BARS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  offset,
    input  logic [1:0]  size_code,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [1:0]  access_status,
    output logic        range_changed,
    output logic [5:0]  active_bars
);

    logic s1_valid_reg, s1_valid_next;
    req_t s1_req_reg;
    logic out_valid_reg, out_valid_next;
    rsp_t out_rsp_reg;
    rsp_t rsp;
    logic in_fire;
    logic advance;

    // Handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_fire  = in_valid && !in_stall;

    // Header state and access decode
    pcicfg_space #(
        .NUM_BARS (NUM_BARS)
    ) u_space (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_write_data (cfg_write_data),
        .fire           (advance),
        .req            (s1_req_reg),
        .rsp            (rsp)
    );

    // Valid tracking for both stages
    always_comb
    begin
        s1_valid_next  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and response payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_req_reg <= '{mode: mode, offset: offset, size_code: size_code,
                            write_data: write_data};
        end
        if (advance)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_rsp_reg.read_data;
    assign access_status = out_rsp_reg.access_status;
    assign range_changed = out_rsp_reg.range_changed;
    assign active_bars   = out_rsp_reg.active_bars;

endmodule

// ===== rtl/pcicfg_space.sv =====
`timescale 1ns / 1ps

module pcicfg_space
    import pcicfg_pkg::*;
#(
    parameter int NUM_BARS = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_write_data,
    input  logic        fire,
    input  req_t        req,
    output rsp_t        rsp
);

    // Fixed identification fields
    logic [31:0] id_word_reg, id_word_next;
    logic [31:0] class_word_reg, class_word_next;
    logic [15:0] hdr_hi_reg, hdr_hi_next;
    logic [23:0] irq_hi_reg, irq_hi_next;
    logic [31:0] subsys_reg, subsys_next;
    logic [35:0] bar_codes_reg, bar_codes_next;

    // Writable header state
    logic [15:0] command_reg, command_next;
    logic [15:0] status_reg, status_next;
    logic [7:0]  cache_line_reg, cache_line_next;
    logic [7:0]  latency_reg, latency_next;
    logic [7:0]  int_line_reg, int_line_next;
    logic [31:0] rom_base_reg, rom_base_next;
    logic [31:0] bar_reg [NUM_BARS];
    logic [31:0] bar_next [NUM_BARS];
    logic [NUM_BARS-1:0] bar_active_reg, bar_active_next;

    logic [31:0]         bar_ext [MAX_BARS];
    logic [MAX_BARS-1:0] active_ext;
    logic [15:0][31:0]   hdr_words;
    logic [511:0]        hdr_flat;
    logic [31:0]         rd_data;
    status_t             status;
    logic                changed;
    logic                is_write;
    logic                bar_hit;
    logic [3:0]          bar_sel;

    // Present BARs padded out to the full header slot count
    for (genvar g = 0; g < MAX_BARS; g++)
    begin : g_pad
        if (g < NUM_BARS)
        begin : g_on
            assign bar_ext[g]    = bar_reg[g];
            assign active_ext[g] = bar_active_next[g];
        end
        else
        begin : g_off
            assign bar_ext[g]    = 32'd0;
            assign active_ext[g] = 1'b0;
        end
    end

    // Header image as seen by reads
    always_comb
    begin
        hdr_words = '0;
        hdr_words[W_ID]        = id_word_reg;
        hdr_words[W_CMD_STAT]  = {status_reg, command_reg};
        hdr_words[W_CLASS]     = class_word_reg;
        hdr_words[W_HEADER]    = {hdr_hi_reg, latency_reg, cache_line_reg};
        for (int i = 0; i < MAX_BARS; i++)
        begin
            hdr_words[W_BAR0 + 4'(i)] = bar_ext[i];
        end
        hdr_words[W_SUBSYSTEM] = subsys_reg;
        hdr_words[W_ROM]       = rom_base_reg;
        hdr_words[W_IRQ]       = {irq_hi_reg, int_line_reg};
    end

    assign hdr_flat = hdr_words;

    // Read path: up to four bytes, zero past the end of the header
    always_comb
    begin
        logic [6:0] addr;
        rd_data = '0;
        for (int k = 0; k < 4; k++)
        begin
            addr = {1'b0, req.offset[5:0]} + 7'(k);
            if (!addr[6] && (k < (1 << req.size_code)))
            begin
                rd_data[8*k +: 8] = hdr_flat[{addr[5:0], 3'b000} +: 8];
            end
        end
    end

    assign is_write = (req.mode == MODE_WRITE);
    assign bar_sel  = req.offset[5:2] - W_BAR0;
    assign bar_hit  = (req.offset[1:0] == 2'b00) && (req.offset[7:6] == 2'b00)
                      && (req.offset[5:2] >= W_BAR0) && (bar_sel < 4'(NUM_BARS));

    // State update: configuration writes, then one access
    always_comb
    begin
        logic [31:0] keep;
        logic [31:0] nv;
        id_word_next    = id_word_reg;
        class_word_next = class_word_reg;
        hdr_hi_next     = hdr_hi_reg;
        irq_hi_next     = irq_hi_reg;
        subsys_next     = subsys_reg;
        bar_codes_next  = bar_codes_reg;
        command_next    = command_reg;
        status_next     = status_reg;
        cache_line_next = cache_line_reg;
        latency_next    = latency_reg;
        int_line_next   = int_line_reg;
        rom_base_next   = rom_base_reg;
        bar_next        = bar_reg;
        bar_active_next = bar_active_reg;
        status          = ST_OK;
        changed         = 1'b0;
        keep            = '0;
        nv              = '0;

        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_ID:        id_word_next    = cfg_write_data[31:0];
                CFG_CLASS:     class_word_next = cfg_write_data[31:0];
                CFG_HEADER:
                begin
                    hdr_hi_next     = cfg_write_data[31:16];
                    latency_next    = cfg_write_data[15:8];
                    cache_line_next = cfg_write_data[7:0];
                end
                CFG_IRQ:
                begin
                    irq_hi_next   = cfg_write_data[31:8];
                    int_line_next = cfg_write_data[7:0];
                end
                CFG_SUBSYSTEM: subsys_next = cfg_write_data[31:0];
                CFG_CMD_STAT:
                begin
                    command_next = cfg_write_data[15:0];
                    status_next  = cfg_write_data[31:16];
                end
                CFG_BAR_SIZE:  bar_codes_next = cfg_write_data;
                CFG_BAR_IO:
                begin
                    for (int i = 0; i < NUM_BARS; i++)
                    begin
                        bar_next[i] = {31'd0, cfg_write_data[i]};
                    end
                end
                default: ;
            endcase
        end

        // Access decode
        if (req.offset >= OFS_DEV_SPEC)
        begin
            status = ST_DEV_SPECIFIC;
        end
        else if (req.size_code == SZ_BAD)
        begin
            status = ST_BAD_SIZE;
        end
        else if (is_write)
        begin
            unique case (req.size_code)
                SZ_BYTE:
                begin
                    unique case (req.offset)
                        OFS_INT_LINE: if (fire) int_line_next = req.write_data[7:0];
                        OFS_CACHE:    if (fire) cache_line_next = req.write_data[7:0];
                        OFS_LATENCY:  if (fire) latency_next = req.write_data[7:0];
                        OFS_REVISION, OFS_CLASS, OFS_INT_PIN, OFS_MIN_GNT,
                        OFS_MAX_LAT: ;
                        default:      status = ST_READ_ONLY;
                    endcase
                end
                SZ_HALF:
                begin
                    unique case (req.offset)
                        OFS_COMMAND: if (fire) command_next = req.write_data[15:0];
                        OFS_STATUS:  if (fire) status_next = req.write_data[15:0];
                        OFS_CACHE:   if (fire) cache_line_next = req.write_data[7:0];
                        default:     status = ST_READ_ONLY;
                    endcase
                end
                default:
                begin
                    if (bar_hit)
                    begin
                        for (int i = 0; i < NUM_BARS; i++)
                        begin
                            if (bar_sel == 4'(i))
                            begin
                                keep = bar_reg[i][0] ? 32'h3 : 32'hF;
                                if (req.write_data == ALL_ONES)
                                begin
                                    nv = bar_size_mask(bar_codes_reg[6*i +: 6]);
                                end
                                else
                                begin
                                    nv = req.write_data & ~keep;
                                    if (nv != 32'd0)
                                    begin
                                        changed = 1'b1;
                                        if (fire) bar_active_next[i] = 1'b1;
                                    end
                                end
                                if (fire) bar_next[i] = (nv & ~keep) | (bar_reg[i] & keep);
                            end
                        end
                    end
                    else if (req.offset == OFS_ROM)
                    begin
                        if (fire) rom_base_next = (req.write_data == ROM_PROBE) ?
                                                  ALL_ONES : req.write_data;
                    end
                    else if (req.offset == OFS_COMMAND)
                    begin
                        if (fire) command_next = req.write_data[15:0];
                    end
                end
            endcase
        end
    end

    // Result of the access in flight
    always_comb
    begin
        rsp.read_data     = (status == ST_OK && !is_write) ? rd_data : 32'd0;
        rsp.access_status = status;
        rsp.range_changed = changed;
        rsp.active_bars   = active_ext;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_word_reg    <= '0;
            class_word_reg <= '0;
            hdr_hi_reg     <= '0;
            irq_hi_reg     <= '0;
            subsys_reg     <= '0;
            bar_codes_reg  <= '0;
            command_reg    <= '0;
            status_reg     <= '0;
            cache_line_reg <= '0;
            latency_reg    <= '0;
            int_line_reg   <= '0;
            rom_base_reg   <= '0;
            bar_active_reg <= '0;
            for (int i = 0; i < NUM_BARS; i++)
            begin
                bar_reg[i] <= '0;
            end
        end
        else
        begin
            id_word_reg    <= id_word_next;
            class_word_reg <= class_word_next;
            hdr_hi_reg     <= hdr_hi_next;
            irq_hi_reg     <= irq_hi_next;
            subsys_reg     <= subsys_next;
            bar_codes_reg  <= bar_codes_next;
            command_reg    <= command_next;
            status_reg     <= status_next;
            cache_line_reg <= cache_line_next;
            latency_reg    <= latency_next;
            int_line_reg   <= int_line_next;
            rom_base_reg   <= rom_base_next;
            bar_active_reg <= bar_active_next;
            bar_reg        <= bar_next;
        end
    end

endmodule
